// File: hdl/wid_pkg.sv
// ----------------------------------------------------------------------------
// work-group id dispatcher package
// shared widths, register indexes and the control / status bundles
// ----------------------------------------------------------------------------
`default_nettype none

package wid_pkg;

   localparam int MAX_DIMS  = 3;
   localparam int DIM_BITS  = 20;
   localparam int DIM_IDX_W = 2;
   localparam int CFG_W     = 60;
   localparam int ID_W      = 60;
   localparam int OFS_W     = 22;
   localparam int FIRST_W   = 8;
   localparam int STRIDE_W  = 9;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 2 * DIM_BITS;
   // carry into a dimension stays below 2^(max(dim bits, stride bits) + 3)
   localparam int CARRY_W   = ((DIM_BITS > STRIDE_W) ? DIM_BITS : STRIDE_W) + 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WORK_DIMS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_COUNTS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_SIZES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_SIZES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_BASES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_GROUPS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ID     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_STRIDE    = 3'd7;

   typedef struct packed {
      logic [1:0]          work_dims;
      logic [CFG_W-1:0]    group_counts;
      logic [CFG_W-1:0]    local_sizes;
      logic [CFG_W-1:0]    global_sizes;
      logic [CFG_W-1:0]    global_bases;
      logic [ID_W-1:0]     total_groups;
      logic [FIRST_W-1:0]  first_id;
      logic [STRIDE_W-1:0] id_stride;
   } wid_cfg_type;

   typedef struct packed {
      logic                 accept;
      logic                 check;
      logic                 add;
      logic                 div_take;
      logic                 mul;
      logic                 fin;
      logic                 publish;
      logic [DIM_IDX_W-1:0] dim;
   } wid_cmd_type;

   typedef struct packed {
      logic exhausted;
      logic fits;
      logic div_done;
      logic last_dim;
      logic out_free;
   } wid_sts_type;

   function automatic logic [DIM_BITS-1:0] field_of(input logic [CFG_W-1:0] packed_v,
                                                   input logic [DIM_IDX_W-1:0] d);
      logic [CFG_W-1:0] sh;
      sh = packed_v >> (32'(d) * DIM_BITS);
      return sh[DIM_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/workgroup_id_dispatcher.sv
// ----------------------------------------------------------------------------
// workgroup_id_dispatcher
// hands out strided work-group ids to one worker, with per-dimension ids,
// global offsets and clipped local sizes
// ----------------------------------------------------------------------------
// flow: accept, check, then an add per dimension until one absorbs the carry,
//   each carrying one passing through the shared 23-step divider; then multiply
//   and finish for every dimension, and publish; an exhausted fetch goes from
//   check straight to publish. One item at a time; the next item is taken while
//   the last result waits
// reset: synchronous, ids and next id to zero, registers to their reset values
// ----------------------------------------------------------------------------
`default_nettype none

module workgroup_id_dispatcher import wid_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_restart,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_has_group,
   output logic [DIM_BITS-1:0]       rsp_group_x,
   output logic [DIM_BITS-1:0]       rsp_group_y,
   output logic [DIM_BITS-1:0]       rsp_group_z,
   output logic [OFS_W-1:0]          rsp_offset_x,
   output logic [OFS_W-1:0]          rsp_offset_y,
   output logic [OFS_W-1:0]          rsp_offset_z,
   output logic [DIM_BITS-1:0]       rsp_size_x,
   output logic [DIM_BITS-1:0]       rsp_size_y,
   output logic [DIM_BITS-1:0]       rsp_size_z,
   // register write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   // register values after reset: one dimension, stride one, all else zero
   localparam wid_cfg_type CFG_RESET = {2'd1, {(4*CFG_W+ID_W){1'b0}}, {FIRST_W{1'b0}},
                                        {(STRIDE_W-1){1'b0}}, 1'b1};

   // configuration registers
   wid_cfg_type cfg_ff, cfg_in;
   wid_cmd_type cmd;
   wid_sts_type sts;

   // writes must come only while idle, unenforced by the block; all are taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WORK_DIMS:    cfg_in.work_dims    = csr_data[1:0];
            CSR_GROUP_COUNTS: cfg_in.group_counts = csr_data;
            CSR_LOCAL_SIZES:  cfg_in.local_sizes  = csr_data;
            CSR_GLOBAL_SIZES: cfg_in.global_sizes = csr_data;
            CSR_GLOBAL_BASES: cfg_in.global_bases = csr_data;
            CSR_TOTAL_GROUPS: cfg_in.total_groups = csr_data;
            CSR_FIRST_ID:     cfg_in.first_id     = csr_data[FIRST_W-1:0];
            CSR_ID_STRIDE:    cfg_in.id_stride    = csr_data[STRIDE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: accepts the item and steps the datapath through the walk
   wid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // walk state, divider, multiplier and output register
   wid_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .req_restart   (req_restart),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_has_group (rsp_has_group),
      .rsp_group_x   (rsp_group_x),
      .rsp_group_y   (rsp_group_y),
      .rsp_group_z   (rsp_group_z),
      .rsp_offset_x  (rsp_offset_x),
      .rsp_offset_y  (rsp_offset_y),
      .rsp_offset_z  (rsp_offset_z),
      .rsp_size_x    (rsp_size_x),
      .rsp_size_y    (rsp_size_y),
      .rsp_size_z    (rsp_size_z)
   );

   // an empty answer carries nothing but the flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_group) |->
         (rsp_group_x == '0 && rsp_offset_x == '0 && rsp_size_x == '0 &&
          rsp_size_y == '0 && rsp_size_z == '0))
      else $error("empty item has non-zero fields");

   // with one dimension in use the upper two read as group 0, size 1
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_group &&
       (cfg_ff.work_dims == 2'd0 || cfg_ff.work_dims == 2'd1)) |->
         (rsp_group_y == '0 && rsp_offset_z == '0 &&
          rsp_size_y == {{(DIM_BITS-1){1'b0}}, 1'b1} &&
          rsp_size_z == {{(DIM_BITS-1){1'b0}}, 1'b1}))
      else $error("unused dimension not reported as group 0 size 1");

   // one item in flight: an accepted request blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted while busy");

endmodule

`default_nettype wire

// File: hdl/wid_div.sv
// ----------------------------------------------------------------------------
// wid_div
// restoring divider, one quotient bit per cycle, for the carry step
// ----------------------------------------------------------------------------
`default_nettype none

module wid_div import wid_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [CARRY_W-1:0]  dividend,
   input  wire logic [DIM_BITS-1:0] divisor,
   output logic                     done,
   output logic [CARRY_W-1:0]       quotient,
   output logic [DIM_BITS-1:0]      remainder
);

   localparam int CNT_W = $clog2(CARRY_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CARRY_W-1:0]  quo_ff, quo_in;
   logic [DIM_BITS-1:0] rem_ff, rem_in;
   logic [DIM_BITS-1:0] dsr_ff, dsr_in;

   logic [DIM_BITS:0]   shifted;
   logic [DIM_BITS+1:0] diff;
   logic                ge;

   always_comb begin
      shifted  = {rem_ff, quo_ff[CARRY_W-1]};
      diff     = {1'b0, shifted} - {2'b00, dsr_ff};
      ge       = ~diff[DIM_BITS+1];
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = CNT_W'(CARRY_W - 1);
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
         quo_in = {quo_ff[CARRY_W-2:0], ge};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: hdl/wid_datapath.sv
// ----------------------------------------------------------------------------
// wid_datapath
// walk state, mixed-radix carry, offset and size per dimension, result register
// ----------------------------------------------------------------------------
`default_nettype none

module wid_datapath import wid_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wid_cfg_type         cfg,
   input  wire wid_cmd_type         cmd,
   input  wire logic                req_restart,
   input  wire logic                rsp_stall,
   output wid_sts_type              sts,
   output logic                     rsp_valid,
   output logic                     rsp_has_group,
   output logic [DIM_BITS-1:0]      rsp_group_x,
   output logic [DIM_BITS-1:0]      rsp_group_y,
   output logic [DIM_BITS-1:0]      rsp_group_z,
   output logic [OFS_W-1:0]         rsp_offset_x,
   output logic [OFS_W-1:0]         rsp_offset_y,
   output logic [OFS_W-1:0]         rsp_offset_z,
   output logic [DIM_BITS-1:0]      rsp_size_x,
   output logic [DIM_BITS-1:0]      rsp_size_y,
   output logic [DIM_BITS-1:0]      rsp_size_z
);

   // walk state
   logic [DIM_BITS-1:0] gid_ff [MAX_DIMS];
   logic [DIM_BITS-1:0] gid_in [MAX_DIMS];
   logic [ID_W-1:0]     next_id_ff, next_id_in;
   logic [STRIDE_W-1:0] delta_ff, delta_in;    // next id minus last issued id

   // working registers
   logic [CARRY_W-1:0]  carry_ff, carry_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                res_has_ff, res_has_in;
   logic [DIM_BITS-1:0] res_grp_ff [MAX_DIMS];
   logic [DIM_BITS-1:0] res_grp_in [MAX_DIMS];
   logic [OFS_W-1:0]    res_ofs_ff [MAX_DIMS];
   logic [OFS_W-1:0]    res_ofs_in [MAX_DIMS];
   logic [DIM_BITS-1:0] res_sz_ff [MAX_DIMS];
   logic [DIM_BITS-1:0] res_sz_in [MAX_DIMS];

   // output register
   logic                out_valid_ff, out_valid_in;
   logic                out_has_ff;
   logic [DIM_BITS-1:0] out_grp_ff [MAX_DIMS];
   logic [OFS_W-1:0]    out_ofs_ff [MAX_DIMS];
   logic [DIM_BITS-1:0] out_sz_ff [MAX_DIMS];

   logic [1:0]          dims_used;
   logic [DIM_BITS-1:0] cur_gid, lim_raw, lim, loc, glob, base;
   logic [CARRY_W-1:0]  val;
   logic                fits, exhausted;
   logic [STRIDE_W-1:0] stride;
   logic [ID_W:0]       sum;
   logic                in_use, le;
   logic [DIM_BITS-1:0] rem_g, fin_sz;
   logic [OFS_W-1:0]    fin_ofs;
   logic                div_done;
   logic [CARRY_W-1:0]  div_quo;
   logic [DIM_BITS-1:0] div_rem;

   always_comb begin
      dims_used = (cfg.work_dims == 2'd0) ? 2'd1 :
                  ((32'(cfg.work_dims) > MAX_DIMS) ? 2'(MAX_DIMS) : cfg.work_dims);
      cur_gid   = gid_ff[cmd.dim];
      lim_raw   = field_of(cfg.group_counts, cmd.dim);
      lim       = (lim_raw == '0) ? {{(DIM_BITS-1){1'b0}}, 1'b1} : lim_raw;
      loc       = field_of(cfg.local_sizes, cmd.dim);
      glob      = field_of(cfg.global_sizes, cmd.dim);
      base      = field_of(cfg.global_bases, cmd.dim);
      val       = {{(CARRY_W-DIM_BITS){1'b0}}, cur_gid} + carry_ff;
      fits      = val < {{(CARRY_W-DIM_BITS){1'b0}}, lim};
      exhausted = next_id_ff >= cfg.total_groups;
      stride    = (cfg.id_stride == '0) ? {{(STRIDE_W-1){1'b0}}, 1'b1} : cfg.id_stride;
      sum       = {1'b0, next_id_ff} + {{(ID_W+1-STRIDE_W){1'b0}}, stride};
      // offset and clipped size from the registered product
      in_use    = cmd.dim < dims_used;
      le        = prod_ff <= {{DIM_BITS{1'b0}}, glob};
      rem_g     = glob - prod_ff[DIM_BITS-1:0];
      fin_sz    = (le && (rem_g < loc)) ? rem_g : loc;
      fin_ofs   = {{(OFS_W-DIM_BITS){1'b0}}, base} + prod_ff[OFS_W-1:0];
   end

   wid_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.add && !fits),
      .dividend  (val),
      .divisor   (lim),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      gid_in     = gid_ff;
      next_id_in = next_id_ff;
      delta_in   = delta_ff;
      carry_in   = carry_ff;
      prod_in    = prod_ff;
      res_has_in = res_has_ff;
      res_grp_in = res_grp_ff;
      res_ofs_in = res_ofs_ff;
      res_sz_in  = res_sz_ff;

      if (cmd.accept && req_restart) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            gid_in[d] = '0;
         end
         next_id_in = {{(ID_W-FIRST_W){1'b0}}, cfg.first_id};
         delta_in   = {{(STRIDE_W-FIRST_W){1'b0}}, cfg.first_id};
      end

      if (cmd.check) begin
         res_has_in = !exhausted;
         if (exhausted) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
               res_grp_in[d] = '0;
               res_ofs_in[d] = '0;
               res_sz_in[d]  = '0;
            end
         end else begin
            carry_in = {{(CARRY_W-STRIDE_W){1'b0}}, delta_ff};
            if (sum[ID_W]) begin
               // saturate, which ends the walk
               next_id_in = '1;
               delta_in   = STRIDE_W'({ID_W{1'b1}} - next_id_ff);
            end else begin
               next_id_in = sum[ID_W-1:0];
               delta_in   = stride;
            end
         end
      end

      if (cmd.add && fits) begin
         gid_in[cmd.dim] = val[DIM_BITS-1:0];
      end

      if (cmd.div_take) begin
         gid_in[cmd.dim] = div_rem;
         carry_in        = div_quo;
      end

      if (cmd.mul) begin
         prod_in = {{DIM_BITS{1'b0}}, cur_gid} * {{DIM_BITS{1'b0}}, loc};
      end

      if (cmd.fin) begin
         if (in_use) begin
            res_grp_in[cmd.dim] = cur_gid;
            res_ofs_in[cmd.dim] = fin_ofs;
            res_sz_in[cmd.dim]  = fin_sz;
         end else begin
            res_grp_in[cmd.dim] = '0;
            res_ofs_in[cmd.dim] = '0;
            res_sz_in[cmd.dim]  = {{(DIM_BITS-1){1'b0}}, 1'b1};
         end
      end

      out_valid_in = out_valid_ff;
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            gid_ff[d] <= '0;
         end
         next_id_ff   <= '0;
         delta_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         gid_ff       <= gid_in;
         next_id_ff   <= next_id_in;
         delta_ff     <= delta_in;
         out_valid_ff <= out_valid_in;
      end
      carry_ff   <= carry_in;
      prod_ff    <= prod_in;
      res_has_ff <= res_has_in;
      res_grp_ff <= res_grp_in;
      res_ofs_ff <= res_ofs_in;
      res_sz_ff  <= res_sz_in;
      if (cmd.publish) begin
         out_has_ff <= res_has_ff;
         out_grp_ff <= res_grp_ff;
         out_ofs_ff <= res_ofs_ff;
         out_sz_ff  <= res_sz_ff;
      end
   end

   always_comb begin
      sts.exhausted = exhausted;
      sts.fits      = fits;
      sts.div_done  = div_done;
      sts.last_dim  = cmd.dim == (dims_used - 2'd1);
      sts.out_free  = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_has_group = out_has_ff;
   assign rsp_group_x   = out_grp_ff[0];
   assign rsp_group_y   = out_grp_ff[1];
   assign rsp_group_z   = out_grp_ff[2];
   assign rsp_offset_x  = out_ofs_ff[0];
   assign rsp_offset_y  = out_ofs_ff[1];
   assign rsp_offset_z  = out_ofs_ff[2];
   assign rsp_size_x    = out_sz_ff[0];
   assign rsp_size_y    = out_sz_ff[1];
   assign rsp_size_z    = out_sz_ff[2];

endmodule

`default_nettype wire

// File: hdl/wid_ctrl.sv
// ----------------------------------------------------------------------------
// wid_ctrl
// sequencer: check, carry through the dimensions, multiply, publish
// ----------------------------------------------------------------------------
`default_nettype none

module wid_ctrl import wid_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire wid_sts_type sts,
   output wid_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [DIM_IDX_W-1:0] dim_ff, dim_in;

   always_comb begin
      state_in = state_ff;
      dim_in   = dim_ff;
      cmd      = '0;
      cmd.dim  = dim_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            dim_in    = '0;
            state_in  = sts.exhausted ? S_DONE : S_ADD;
         end
         S_ADD: begin
            cmd.add = 1'b1;
            if (sts.fits) begin
               dim_in   = '0;
               state_in = S_MUL;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               if (sts.last_dim) begin
                  // carry out of the top dimension is dropped
                  dim_in   = '0;
                  state_in = S_MUL;
               end else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = S_ADD;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin = 1'b1;
            if (32'(dim_ff) == MAX_DIMS - 1) begin
               dim_in   = '0;
               state_in = S_DONE;
            end else begin
               dim_in   = dim_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dim_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dim_ff   <= dim_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

`default_nettype wire

// File: verif/workgroup_id_dispatcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// workgroup_id_dispatcher testbench
// drives fetch requests and register settings into the dispatcher, predicts
// every group it should hand out and checks each result field by field
// ----------------------------------------------------------------------------

module workgroup_id_dispatcher_tb import wid_pkg::*; ();

   localparam int NUM_REGS     = 8;
   localparam int ITEMS_WANTED = 1450;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int DRAIN_CYCLES = 120;
   localparam int MAX_REPORTS  = 10;

   // what one result item carries, x in element 0
   typedef struct {
      bit                               has_group;
      logic [MAX_DIMS-1:0][DIM_BITS-1:0] grp;
      logic [MAX_DIMS-1:0][OFS_W-1:0]    ofs;
      logic [MAX_DIMS-1:0][DIM_BITS-1:0] sz;
   } grant_type;

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} sender_idle_type;
   typedef enum int {STALL_NONE, STALL_SOME, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   // -------------------------------------------------------------------------
   // scoreboard: own copy of the registers and the walk, queue of grants due
   // -------------------------------------------------------------------------
   class dispatch_scoreboard_type;
      wid_cfg_type     cfg;
      logic [63:0]     walk_ids [MAX_DIMS];
      logic [ID_W-1:0] next_id;
      logic [ID_W-1:0] prev_id;
      grant_type       expected_grants [$];
      int unsigned     mismatches, checked, issued, exhausted, restarts;

      function new();
         cfg           = '0;
         cfg.work_dims = 2'd1;
         cfg.id_stride = 9'd1;
         restart_walk();
      endfunction

      function void restart_walk();
         int d;
         for (d = 0; d < MAX_DIMS; d++)
            walk_ids[d] = '0;
         next_id = ID_W'(cfg.first_id);
         prev_id = '0;
      endfunction

      function logic [63:0] dim_field(logic [CFG_W-1:0] word, int d);
         logic [CFG_W-1:0] sh;
         sh = word >> (d * DIM_BITS);
         return 64'(sh[DIM_BITS-1:0]);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_WORK_DIMS:    cfg.work_dims    = val[1:0];
            CSR_GROUP_COUNTS: cfg.group_counts = val;
            CSR_LOCAL_SIZES:  cfg.local_sizes  = val;
            CSR_GLOBAL_SIZES: cfg.global_sizes = val;
            CSR_GLOBAL_BASES: cfg.global_bases = val;
            CSR_TOTAL_GROUPS: cfg.total_groups = val;
            CSR_FIRST_ID:     cfg.first_id     = val[FIRST_W-1:0];
            CSR_ID_STRIDE:    cfg.id_stride    = val[STRIDE_W-1:0];
            default: ;
         endcase
      endfunction

      // advances the walk by one fetch unless the ids have run out, and returns the group it yields
      function grant_type next_grant(bit restart);
         grant_type       g;
         int              dims, d;
         logic [63:0]     adv, lim, val, loc, glob, prod, sum;
         logic [ID_W-1:0] id;
         g.has_group = 1'b0;
         g.grp       = '0;
         g.ofs       = '0;
         g.sz        = '0;
         dims = (cfg.work_dims == 2'd0) ? 1 : int'(cfg.work_dims);
         if (dims > MAX_DIMS) dims = MAX_DIMS;
         if (restart) restart_walk();
         if (next_id >= cfg.total_groups) return g;
         id  = next_id;
         sum = 64'(next_id) + ((cfg.id_stride == '0) ? 64'd1 : 64'(cfg.id_stride));
         next_id = (sum > 64'({ID_W{1'b1}})) ? {ID_W{1'b1}} : sum[ID_W-1:0];
         adv     = 64'(id) - 64'(prev_id);
         prev_id = id;
         // mixed-radix add, carry out of the last dimension is lost
         for (d = 0; d < dims; d++) begin
            lim = dim_field(cfg.group_counts, d);
            if (lim == 64'd0) lim = 64'd1;
            val = walk_ids[d] + adv;
            if (val < lim) begin
               walk_ids[d] = val;
               break;
            end
            adv         = val / lim;
            walk_ids[d] = val - adv * lim;
         end
         g.has_group = 1'b1;
         for (d = 0; d < MAX_DIMS; d++) begin
            if (d < dims) begin
               loc      = dim_field(cfg.local_sizes, d);
               glob     = dim_field(cfg.global_sizes, d);
               prod     = 64'(walk_ids[d][DIM_BITS-1:0]) * loc;
               g.grp[d] = walk_ids[d][DIM_BITS-1:0];
               val      = dim_field(cfg.global_bases, d) + prod;
               g.ofs[d] = val[OFS_W-1:0];
               val      = (prod <= glob && glob - prod < loc) ? glob - prod : loc;
               g.sz[d]  = val[DIM_BITS-1:0];
            end else begin
               g.sz[d] = DIM_BITS'(1);
            end
         end
         return g;
      endfunction

      function void note_fetch(bit restart);
         grant_type g;
         if (restart) restarts++;
         g = next_grant(restart);
         if (g.has_group) issued++;
         else exhausted++;
         expected_grants.push_back(g);
      endfunction

      function void compare(string what, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d: %s expected 0x%0h, got 0x%0h",
                        checked, what, want, got);
         end
      endfunction

      function void check_grant(grant_type got);
         grant_type want;
         string     axis;
         string     ax;
         int        d;
         axis = "xyz";
         checked++;
         if (expected_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d: arrived with no fetch outstanding", checked);
            return;
         end
         want = expected_grants.pop_front();
         compare("has_group", want.has_group, got.has_group);
         for (d = 0; d < MAX_DIMS; d++) begin
            ax = axis.substr(d, d);
            compare({"group_", ax}, want.grp[d], got.grp[d]);
            compare({"offset_", ax}, want.ofs[d], got.ofs[d]);
            compare({"size_", ax}, want.sz[d], got.sz[d]);
         end
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // block under test and its wiring
   // -------------------------------------------------------------------------
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_restart = 1'b0;
   logic                 rsp_stall   = 1'b0;
   logic                 csr_valid   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CFG_W-1:0]     csr_data    = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic                 rsp_has_group;
   logic [DIM_BITS-1:0]  rsp_group_x, rsp_group_y, rsp_group_z;
   logic [OFS_W-1:0]     rsp_offset_x, rsp_offset_y, rsp_offset_z;
   logic [DIM_BITS-1:0]  rsp_size_x, rsp_size_y, rsp_size_z;
   logic                 csr_ready;

   workgroup_id_dispatcher dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_has_group (rsp_has_group),
      .rsp_group_x   (rsp_group_x),
      .rsp_group_y   (rsp_group_y),
      .rsp_group_z   (rsp_group_z),
      .rsp_offset_x  (rsp_offset_x),
      .rsp_offset_y  (rsp_offset_y),
      .rsp_offset_z  (rsp_offset_z),
      .rsp_size_x    (rsp_size_x),
      .rsp_size_y    (rsp_size_y),
      .rsp_size_z    (rsp_size_z),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 12 ns period
   always #6 clock = ~clock;

   dispatch_scoreboard_type sb;

   // stimulus plan for the current phase
   logic [CFG_W-1:0] plan_vals [NUM_REGS];
   bit [NUM_REGS-1:0] plan_mask = '0;
   bit               fetch_plan [$];
   sender_idle_type  gap_mode   = IDLE_NONE;
   stall_mode_type   stall_mode = STALL_NONE;
   bit               held_once  = 1'b0;
   int unsigned      items_sent = 0;
   int unsigned      phases     = 0;
   int unsigned      cycles     = 0;
   int unsigned      stall_tick = 0;

   // -------------------------------------------------------------------------
   // watchdog, reckoned well above the slowest legal run
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, sb.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // monitor: sample both handshakes at the rising edge
   // check first, then note the new fetch; a result never shares its fetch's edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      grant_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.has_group = rsp_has_group;
            got.grp       = {rsp_group_z, rsp_group_y, rsp_group_x};
            got.ofs       = {rsp_offset_z, rsp_offset_y, rsp_offset_x};
            got.sz        = {rsp_size_z, rsp_size_y, rsp_size_x};
            sb.check_grant(got);
         end
         if (req_valid && !req_stall)
            sb.note_fetch(req_restart);
      end
   end

   // -------------------------------------------------------------------------
   // result side back-pressure, its own pattern per phase
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      stall_tick++;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_SOME:     rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= ((stall_tick % 7) < 3);
         default:        rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // -------------------------------------------------------------------------
   // helpers
   // -------------------------------------------------------------------------
   function automatic logic [CFG_W-1:0] rand60();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[CFG_W-1:0];
   endfunction

   // half the time, set junk above the register's real width
   function automatic logic [CFG_W-1:0] with_noise(logic [CFG_W-1:0] v, int w);
      logic [CFG_W-1:0] junk;
      junk = rand60() << w;
      return ($urandom_range(0, 1) == 0) ? v : (v | junk);
   endfunction

   function automatic logic [CFG_W-1:0] pack3(logic [DIM_BITS-1:0] x,
                                              logic [DIM_BITS-1:0] y,
                                              logic [DIM_BITS-1:0] z);
      return {z, y, x};
   endfunction

   // all driving tasks start and end at a falling edge
   task automatic wait_drained();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // register writes; valid stays high across back-to-back writes
   task automatic apply_plan();
      int r;
      for (r = 0; r < NUM_REGS; r++) begin
         if (plan_mask[r]) begin
            csr_valid <= 1'b1;
            csr_index <= CSR_IDX_W'(r);
            csr_data  <= plan_vals[r];
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            sb.write_reg(CSR_IDX_W'(r), plan_vals[r]);
            @(negedge clock);
         end
      end
      csr_valid <= 1'b0;
   endtask

   // sends fetch_plan in bursts; gaps and the odd full drain between bursts
   task automatic run_fetches();
      int idx, burst, gap, k;
      bit hold;
      idx = 0;
      while (idx < fetch_plan.size()) begin
         // first pause comes early so a full drain mid-stream is always seen
         hold  = ($urandom_range(0, 24) == 0) || (!held_once && idx > 0);
         gap   = 0;
         burst = fetch_plan.size();
         case (gap_mode)
            IDLE_LIGHT: begin
               burst = $urandom_range(1, 8);
               gap   = $urandom_range(0, 5);
            end
            IDLE_HEAVY: begin
               burst = $urandom_range(1, 3);
               gap   = $urandom_range(0, 14);
            end
            default: ;
         endcase
         if (gap_mode != IDLE_NONE || hold) begin
            req_valid <= 1'b0;
            @(negedge clock);
            if (hold) begin
               wait_drained();
               held_once = 1'b1;
            end
            repeat (gap) @(negedge clock);
         end
         for (k = 0; k < burst && idx < fetch_plan.size(); k++) begin
            req_valid   <= 1'b1;
            req_restart <= fetch_plan[idx];
            @(posedge clock);
            while (req_stall) @(posedge clock);
            idx++;
            items_sent++;
            @(negedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // one configuration phase: registers while idle, then fetches, then drain
   task automatic run_phase();
      apply_plan();
      run_fetches();
      wait_drained();
      phases++;
   endtask

   task automatic plan_all(logic [CFG_W-1:0] dims, logic [CFG_W-1:0] cnt,
                           logic [CFG_W-1:0] loc, logic [CFG_W-1:0] glob,
                           logic [CFG_W-1:0] base, logic [CFG_W-1:0] total,
                           logic [CFG_W-1:0] first_v, logic [CFG_W-1:0] stride_v);
      plan_vals[CSR_WORK_DIMS]    = dims;
      plan_vals[CSR_GROUP_COUNTS] = cnt;
      plan_vals[CSR_LOCAL_SIZES]  = loc;
      plan_vals[CSR_GLOBAL_SIZES] = glob;
      plan_vals[CSR_GLOBAL_BASES] = base;
      plan_vals[CSR_TOTAL_GROUPS] = total;
      plan_vals[CSR_FIRST_ID]     = first_v;
      plan_vals[CSR_ID_STRIDE]    = stride_v;
      plan_mask = '1;
   endtask

   // random setting: small grids mostly, so carries ripple through y and z,
   // with zero and full-width fields mixed in; walk length roughly matches
   // the number of fetches so that exhaustion and restarts both happen
   task automatic plan_random_phase();
      logic [DIM_BITS-1:0] cnt  [MAX_DIMS];
      logic [DIM_BITS-1:0] loc  [MAX_DIMS];
      logic [DIM_BITS-1:0] glob [MAX_DIMS];
      logic [DIM_BITS-1:0] base [MAX_DIMS];
      logic [63:0]         span, first_v, stride_v, step;
      int                  d, n, pct, k;
      for (d = 0; d < MAX_DIMS; d++) begin
         case ($urandom_range(0, 11))
            0:       cnt[d] = '0;
            1:       cnt[d] = '1;
            2:       cnt[d] = DIM_BITS'($urandom);
            default: cnt[d] = DIM_BITS'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 9))
            0:       loc[d] = '0;
            1:       loc[d] = '1;
            2:       loc[d] = DIM_BITS'($urandom);
            default: loc[d] = DIM_BITS'($urandom_range(1, 40));
         endcase
         // global size just short of the grid, so the last group gets clipped
         span = 64'((cnt[d] == '0) ? DIM_BITS'(1) : cnt[d]) * 64'(loc[d]);
         span = span - 64'($urandom_range(0, loc[d]));
         case ($urandom_range(0, 7))
            0:       glob[d] = '0;
            1:       glob[d] = '1;
            2:       glob[d] = DIM_BITS'($urandom);
            default: glob[d] = span[DIM_BITS-1:0];
         endcase
         case ($urandom_range(0, 5))
            0:       base[d] = '0;
            1:       base[d] = '1;
            default: base[d] = DIM_BITS'($urandom);
         endcase
      end
      case ($urandom_range(0, 5))
         0:       first_v = 64'd255;
         1:       first_v = 64'($urandom_range(0, 255));
         default: first_v = 64'($urandom_range(0, 5));
      endcase
      case ($urandom_range(0, 7))
         0:       stride_v = 64'd0;
         1:       stride_v = 64'd256;
         2:       stride_v = 64'($urandom_range(0, 511));
         default: stride_v = 64'($urandom_range(1, 6));
      endcase
      step = (stride_v == 0) ? 64'd1 : stride_v;
      plan_vals[CSR_WORK_DIMS]    = with_noise(CFG_W'($urandom_range(0, 3)), 2);
      plan_vals[CSR_GROUP_COUNTS] = pack3(cnt[0], cnt[1], cnt[2]);
      plan_vals[CSR_LOCAL_SIZES]  = pack3(loc[0], loc[1], loc[2]);
      plan_vals[CSR_GLOBAL_SIZES] = pack3(glob[0], glob[1], glob[2]);
      plan_vals[CSR_GLOBAL_BASES] = pack3(base[0], base[1], base[2]);
      case ($urandom_range(0, 9))
         0:       plan_vals[CSR_TOTAL_GROUPS] = '0;
         1:       plan_vals[CSR_TOTAL_GROUPS] = rand60();
         2:       plan_vals[CSR_TOTAL_GROUPS] = '1;
         default: plan_vals[CSR_TOTAL_GROUPS] =
                     CFG_W'(first_v + step * 64'($urandom_range(3, 60)));
      endcase
      plan_vals[CSR_FIRST_ID]  = with_noise(CFG_W'(first_v), FIRST_W);
      plan_vals[CSR_ID_STRIDE] = with_noise(CFG_W'(stride_v), STRIDE_W);
      // sometimes leave a few registers as they were
      plan_mask = NUM_REGS'($urandom) | NUM_REGS'($urandom);

      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(10, 60);
      pct = $urandom_range(2, 15);
      fetch_plan.delete();
      for (k = 0; k < n; k++)
         fetch_plan.push_back((k == 0) ? bit'($urandom_range(0, 1))
                                       : ($urandom_range(0, 99) < pct));
      gap_mode   = sender_idle_type'($urandom_range(0, 2));
      stall_mode = stall_mode_type'($urandom_range(0, 3));
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gap_mode   = IDLE_LIGHT;
      stall_mode = STALL_SOME;

      // out of reset: empty range, plain fetch and restart both find nothing
      fetch_plan = '{1'b0, 1'b1};
      run_phase();

      // 3x2x2 grid, ids 1, 6, 11 then exhausted; clipping in x and y,
      // x beyond its global size at id 11, zero global size in z
      plan_all(CFG_W'(3), pack3(20'd3, 20'd2, 20'd2), pack3(20'd4, 20'd5, '1),
               pack3(20'd6, 20'd7, 20'd0), pack3('1, 20'h12345, '1),
               CFG_W'(12), CFG_W'(1), CFG_W'(5));
      fetch_plan = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      run_phase();

      // zero dimension count acts as one, zero group count drops every carry,
      // zero stride steps by one, junk above the first id
      plan_all(CFG_W'(0), pack3(20'd0, 20'd5, 20'd5), pack3(20'd3, 20'd3, 20'd3),
               pack3(20'd2, 20'd9, 20'd9),
               pack3(20'h00001, 20'h54321, 20'h0ABCD), CFG_W'(6),
               60'hABC_DEF0_1234_5603, CFG_W'(0));
      fetch_plan = '{1'b1, 1'b0, 1'b0, 1'b0};
      gap_mode   = IDLE_NONE;
      stall_mode = STALL_NONE;
      run_phase();

      // every other register at full width, largest first id and stride 256
      plan_all('1, '1, '1, '1, '1, '1, CFG_W'(255), CFG_W'(256));
      fetch_plan = '{1'b1, 1'b0, 1'b0};
      gap_mode   = IDLE_HEAVY;
      stall_mode = STALL_HEAVY;
      run_phase();

      // drop to two dimensions mid-walk, junk in the upper data bits
      plan_mask = '0;
      plan_mask[CSR_WORK_DIMS]  = 1'b1;
      plan_vals[CSR_WORK_DIMS]  = 60'hFFF_FFFF_FFFF_FFFE;
      fetch_plan = '{1'b0, 1'b0};
      stall_mode = STALL_PERIODIC;
      run_phase();

      // random settings until enough fetches have gone in
      while (items_sent < ITEMS_WANTED) begin
         plan_random_phase();
         run_phase();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d fetches over %0d settings: %0d groups issued, %0d none left, %0d restarts",
               items_sent, phases, sb.issued, sb.exhausted, sb.restarts);
      $display("%0d results checked, %0d mismatches, %0d results missing",
               sb.checked, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: workgroup_id_dispatcher.f
hdl/wid_pkg.sv
hdl/wid_div.sv
hdl/wid_datapath.sv
hdl/wid_ctrl.sv
hdl/workgroup_id_dispatcher.sv
verif/workgroup_id_dispatcher_tb.sv
